### rtl/cht_pkg.sv
// Shared types, widths and codes for the chained hash table core.
// No dependencies; imported by every module of the block but cht_ram.
package cht_pkg;

    localparam int MAX_BUCKETS = 1024;
    localparam int POOL_DEPTH  = 1024;

    localparam int KEY_W   = 31;
    localparam int NAME_W  = 16;
    localparam int YEAR_W  = 12;
    localparam int GRADE_W = 10;
    localparam int BC_W    = 11;
    localparam int STAT_W  = 2;

    localparam int BKT_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NODE_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
    localparam int LOAD_W  = CNT_W + 5;
    localparam int DIV_CNT_W = $clog2(KEY_W);

    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECTED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [NAME_W-1:0]  name_handle;
        logic [YEAR_W-1:0]  birth_year;
        logic               gender;
        logic [GRADE_W-1:0] grade_avg;
    } cht_rec_t;

    // link word: valid flag plus node index
    typedef struct packed {
        logic              ok;
        logic [NODE_W-1:0] idx;
    } cht_link_t;

    // status of the modulo unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [BC_W-1:0]  rem;
    } cht_mod_stat_t;

endpackage

### rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/cht_mod_unit.sv
// Bit-serial restoring modulo unit: key mod bucket count, one bit a cycle.
// Depends on cht_pkg.
module cht_mod_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cht_pkg::KEY_W-1:0]  dividend,
    input  logic [cht_pkg::BC_W-1:0]   divisor,
    output cht_pkg::cht_mod_stat_t     stat
);
    import cht_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_BIT = DIV_CNT_W'(KEY_W - 1);

    logic [KEY_W-1:0]     dvd_reg, dvd_next;
    logic [BC_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BC_W:0]        trial;

    // one shift, compare and subtract step
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[KEY_W-1]};
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = BC_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[BC_W-1:0];
            end
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;
endmodule

### rtl/chained_hash_table_core.sv
// Top level of the chained hash table: sequencer, head/tail/node memories.
// Depends on cht_pkg, cht_ram and cht_mod_unit.
//
// The core takes one transaction at a time. The bucket is found by a
// bit-serial modulo unit in 31 shift steps. An insert into an empty bucket
// reads the head and then writes the node and the head; one behind an
// existing chain reads head and tail, writes the node and then links the old
// tail. A search that stops at an empty bucket answers after the head read,
// and one that walks the chain reads each node through the registered read
// of the node memory; a refused insert answers on the next cycle. The result
// is held until taken or cleared by a bucket_count write, and the core is
// ready again in the cycle after it is taken. Input is held off while a
// bucket_count write is offered. After reset and after every bucket_count
// write the core runs a clearing pass over the whole bucket head memory,
// during which no item is accepted.
module chained_hash_table_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cht_pkg::BC_W-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [cht_pkg::KEY_W-1:0]    key,
    input  logic [cht_pkg::NAME_W-1:0]   name_handle,
    input  logic [cht_pkg::YEAR_W-1:0]   birth_year,
    input  logic                         gender,
    input  logic [cht_pkg::GRADE_W-1:0]  grade_avg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cht_pkg::STAT_W-1:0]   status,
    output logic [cht_pkg::KEY_W-1:0]    found_key,
    output logic [cht_pkg::NAME_W-1:0]   found_name_handle,
    output logic [cht_pkg::YEAR_W-1:0]   found_birth_year,
    output logic                         found_gender,
    output logic [cht_pkg::GRADE_W-1:0]  found_grade_avg
);
    import cht_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MOD   = 9'b000000100,
        S_HRD   = 9'b000001000,
        S_HUSE  = 9'b000010000,
        S_LINK  = 9'b000100000,
        S_WRD   = 9'b001000000,
        S_WCMP  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(MAX_BUCKETS - 1);
    localparam logic [BC_W-1:0]  BC_MAX   = BC_W'(MAX_BUCKETS);
    localparam logic [BC_W-1:0]  BC_RESET = BC_W'((MAX_BUCKETS < 1024) ? MAX_BUCKETS : 1024);

    state_t             state_reg, state_next;
    logic [BC_W-1:0]    bc_reg, bc_next;
    logic [CNT_W-1:0]   entry_reg, entry_next;
    logic [BKT_W-1:0]   clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;

    logic               func_reg;
    cht_rec_t           item_reg;
    logic [NODE_W-1:0]  n_reg;
    logic [BKT_W-1:0]   b_reg;
    logic [NODE_W-1:0]  p_reg, p_next;
    logic [NODE_W-1:0]  t_reg;
    logic [STAT_W-1:0]  status_reg, status_next;
    cht_rec_t           res_reg, res_next;

    logic               cfg_fire, in_fire;
    logic [BC_W-1:0]    cfg_clamped;
    logic [LOAD_W-1:0]  load_lhs, load_rhs;
    logic               reject;

    logic               mod_start;
    cht_mod_stat_t      mod_stat;

    logic               head_we;
    logic [BKT_W-1:0]   head_waddr;
    cht_link_t          head_wdata, head_rdata;
    logic               tail_we;
    logic [NODE_W-1:0]  tail_rdata;
    logic               rec_we;
    cht_rec_t           rec_rdata;
    logic               next_we;
    logic [NODE_W-1:0]  next_waddr;
    cht_link_t          next_wdata, next_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_fire   = in_valid && in_ready;

    // clamp of a bucket count write
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = BC_W'(1);
        end
        else if (cfg_data > BC_MAX)
        begin
            cfg_clamped = BC_MAX;
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // load limit 10*(entries+1) >= 7*buckets, or pool full
    assign load_lhs = LOAD_W'(10) * (LOAD_W'(entry_reg) + LOAD_W'(1));
    assign load_rhs = LOAD_W'(7) * LOAD_W'(bc_reg);
    assign reject   = (load_lhs >= load_rhs) || (entry_reg >= CNT_W'(POOL_DEPTH));

    assign mod_start = in_fire && !cfg_fire && !((func == FUNC_INSERT) && reject);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        bc_next        = bc_reg;
        entry_next     = entry_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        p_next         = p_reg;
        head_we        = 1'b0;
        head_waddr     = b_reg;
        head_wdata     = '{ok: 1'b1, idx: n_reg};
        tail_we        = 1'b0;
        rec_we         = 1'b0;
        next_we        = 1'b0;
        next_waddr     = n_reg;
        next_wdata     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LAST_BKT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if ((func == FUNC_INSERT) && reject)
                    begin
                        status_next    = ST_REJECTED;
                        res_next       = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_stat.done)
                begin
                    state_next = S_HRD;
                end
            end
            S_HRD:
            begin
                state_next = S_HUSE;
            end
            S_HUSE:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    rec_we     = 1'b1;
                    next_we    = 1'b1;
                    tail_we    = 1'b1;
                    entry_next = entry_reg + 1'b1;
                    if (!head_rdata.ok)
                    begin
                        head_we        = 1'b1;
                        status_next    = ST_INSERTED;
                        res_next       = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
                else if (!head_rdata.ok)
                begin
                    status_next    = ST_NOT_FOUND;
                    res_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    p_next     = head_rdata.idx;
                    state_next = S_WRD;
                end
            end
            S_LINK:
            begin
                next_we        = 1'b1;
                next_waddr     = t_reg;
                next_wdata     = '{ok: 1'b1, idx: n_reg};
                status_next    = ST_INSERTED;
                res_next       = '0;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_WRD:
            begin
                state_next = S_WCMP;
            end
            S_WCMP:
            begin
                if (rec_rdata.key == item_reg.key)
                begin
                    status_next    = ST_FOUND;
                    res_next       = rec_rdata;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else if (next_rdata.ok)
                begin
                    p_next     = next_rdata.idx;
                    state_next = S_WRD;
                end
                else
                begin
                    status_next    = ST_NOT_FOUND;
                    res_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // a bucket count write empties the table and restarts the sweep
        if (cfg_fire)
        begin
            bc_next        = cfg_clamped;
            entry_next     = '0;
            clr_next       = '0;
            out_valid_next = 1'b0;
            state_next     = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            bc_reg        <= BC_RESET;
            entry_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            entry_reg     <= entry_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction payload and walk registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg              <= func;
            item_reg.key          <= key;
            item_reg.name_handle  <= name_handle;
            item_reg.birth_year   <= birth_year;
            item_reg.gender       <= gender;
            item_reg.grade_avg    <= grade_avg;
            n_reg                 <= entry_reg[NODE_W-1:0];
        end
        if (mod_stat.done)
        begin
            b_reg <= mod_stat.rem[BKT_W-1:0];
        end
        if (state_reg == S_HUSE)
        begin
            t_reg <= tail_rdata;
        end
        p_reg      <= p_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    cht_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (key),
        .divisor  (bc_reg),
        .stat     (mod_stat)
    );

    cht_ram #(.WIDTH($bits(cht_link_t)), .DEPTH(MAX_BUCKETS)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (b_reg),
        .rdata (head_rdata)
    );

    cht_ram #(.WIDTH(NODE_W), .DEPTH(MAX_BUCKETS)) u_tail (
        .clk   (clk),
        .we    (tail_we),
        .waddr (b_reg),
        .wdata (n_reg),
        .raddr (b_reg),
        .rdata (tail_rdata)
    );

    cht_ram #(.WIDTH($bits(cht_rec_t)), .DEPTH(POOL_DEPTH)) u_rec (
        .clk   (clk),
        .we    (rec_we),
        .waddr (n_reg),
        .wdata (item_reg),
        .raddr (p_reg),
        .rdata (rec_rdata)
    );

    cht_ram #(.WIDTH($bits(cht_link_t)), .DEPTH(POOL_DEPTH)) u_next (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (p_reg),
        .rdata (next_rdata)
    );

    // result port
    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign found_key         = res_reg.key;
    assign found_name_handle = res_reg.name_handle;
    assign found_birth_year  = res_reg.birth_year;
    assign found_gender      = res_reg.gender;
    assign found_grade_avg   = res_reg.grade_avg;
endmodule

### rtl/cht_checker.sv
// Port-level checker for the chained hash table core, with its bind.
// Depends on cht_pkg and the ports of chained_hash_table_core.
module cht_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [cht_pkg::BC_W-1:0]     cfg_data,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         func,
    input logic [cht_pkg::KEY_W-1:0]    key,
    input logic [cht_pkg::NAME_W-1:0]   name_handle,
    input logic [cht_pkg::YEAR_W-1:0]   birth_year,
    input logic                         gender,
    input logic [cht_pkg::GRADE_W-1:0]  grade_avg,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cht_pkg::STAT_W-1:0]   status,
    input logic [cht_pkg::KEY_W-1:0]    found_key,
    input logic [cht_pkg::NAME_W-1:0]   found_name_handle,
    input logic [cht_pkg::YEAR_W-1:0]   found_birth_year,
    input logic                         found_gender,
    input logic [cht_pkg::GRADE_W-1:0]  found_grade_avg
);
    import cht_pkg::*;

    // one transaction at a time: no new input while a result is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // an accepted input closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a transaction");

    // a bucket count write starts the clearing pass
    a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (!in_ready && !out_valid))
        else $error("core not clearing after a bucket count write");

    // only a found record carries record fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_FOUND)) |->
        (found_key == '0 && found_name_handle == '0 && found_birth_year == '0
         && found_gender == 1'b0 && found_grade_avg == '0))
        else $error("record fields set on a result without a match");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && !(cfg_valid && cfg_ready)) |=>
        (out_valid && $stable(status) && $stable(found_key)))
        else $error("result changed while stalled");
endmodule

bind chained_hash_table_core cht_checker u_cht_checker (.*);
